FILE: hdl/hfbr_pkg.sv
// Package: shared constants, types and helpers of the header framed byte router.
package hfbr_pkg;

  localparam int HEADER_BYTES    = 4;
  localparam int BYTE_W          = 8;
  // The header store always covers the four bytes that the result carries.
  localparam int HDR_STORE_DEPTH = (HEADER_BYTES > 4) ? HEADER_BYTES : 4;
  localparam int HIDX_W          = $clog2(HDR_STORE_DEPTH);
  localparam int DEST_W          = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] HEADER_LEN = BYTE_W'(HEADER_BYTES);

  localparam logic [DEST_W-1:0] GENERAL_QUEUE = DEST_W'(4);
  localparam logic              KIND_HEADER   = 1'b0;
  localparam logic              KIND_PAYLOAD  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic              item_kind;
    logic [DEST_W-1:0] destination;
    byte_t             payload_byte;
    byte_t             header_type;
    byte_t             header_length;
    byte_t             header_third;
    byte_t             header_fourth;
  } hfbr_result_t;

  typedef struct packed {
    logic         valid;
    hfbr_result_t data;
  } hfbr_push_t;

  // Types 1 to 4 select axis queues 0 to 3; anything else goes to the general queue.
  function automatic logic [DEST_W-1:0] route_of(input byte_t frame_type);
    logic [DEST_W-1:0] dest;
    if (frame_type inside {[8'd1:8'd4]}) begin
      dest = DEST_W'(frame_type - 8'd1);
    end else begin
      dest = GENERAL_QUEUE;
    end
    return dest;
  endfunction

endpackage

FILE: hdl/hfbr_stream_if.sv
// Interfaces: the byte input channel and the routed result channel.
interface hfbr_in_if import hfbr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface hfbr_out_if import hfbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              item_kind;
  logic [DEST_W-1:0] destination;
  byte_t             payload_byte;
  byte_t             header_type;
  byte_t             header_length;
  byte_t             header_third;
  byte_t             header_fourth;

  modport source (output valid, output item_kind, output destination, output payload_byte,
                  output header_type, output header_length, output header_third,
                  output header_fourth, input ready);
  modport sink   (input valid, input item_kind, input destination, input payload_byte,
                  input header_type, input header_length, input header_third,
                  input header_fourth, output ready);
endinterface

FILE: hdl/hfbr_front.sv
// Front end: takes input bytes, tracks the frame and classifies each item.
module hfbr_front import hfbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hfbr_in_if.sink     in_ch,
  input  logic        q_full,
  output hfbr_push_t  push
);

  byte_t       hdr_r   [HDR_STORE_DEPTH];
  byte_t       hdr_cur [HDR_STORE_DEPTH];
  byte_t       cnt_r, cnt_nxt;
  byte_t       end_r, end_nxt;
  byte_t       cnt_inc;
  byte_t       len_diff;
  byte_t       pay_len;
  logic        accept;
  logic        hdr_phase;
  logic        hdr_last;
  logic [HIDX_W-1:0] hidx;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign hdr_phase   = (cnt_r < HEADER_LEN);
  assign hidx        = cnt_r[HIDX_W-1:0];
  assign cnt_inc     = cnt_r + 8'd1;
  assign hdr_last    = hdr_phase && (cnt_inc == HEADER_LEN);

  // Header as it stands once the current byte is stored.
  always_comb begin
    for (int i = 0; i < HDR_STORE_DEPTH; i++) begin
      hdr_cur[i] = (hdr_phase && (hidx == HIDX_W'(i))) ? in_ch.data_byte : hdr_r[i];
    end
  end

  // Payload is the length past the header rounded down to whole groups of four.
  always_comb begin
    len_diff = hdr_cur[1] - HEADER_LEN;
    pay_len  = 8'd0;
    if (hdr_cur[1] >= HEADER_LEN) begin
      pay_len = {len_diff[BYTE_W-1:2], 2'b00};
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    end_nxt = end_r;
    if (accept) begin
      if (hdr_phase) begin
        cnt_nxt = cnt_inc;
        if (hdr_last) begin
          end_nxt = HEADER_LEN + pay_len;
          if (pay_len == 8'd0) begin
            cnt_nxt = 8'd0;
          end
        end
      end else begin
        cnt_nxt = (cnt_inc >= end_r) ? 8'd0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      end_r <= '0;
      for (int i = 0; i < HDR_STORE_DEPTH; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      end_r <= end_nxt;
      if (accept && hdr_phase) begin
        hdr_r[hidx] <= in_ch.data_byte;
      end
    end
  end

  always_comb begin
    push.valid              = accept && (!hdr_phase || hdr_last);
    push.data.item_kind     = hdr_phase ? KIND_HEADER : KIND_PAYLOAD;
    push.data.destination   = route_of(hdr_cur[0]);
    push.data.payload_byte  = hdr_phase ? 8'd0 : in_ch.data_byte;
    push.data.header_type   = hdr_cur[0];
    push.data.header_length = hdr_cur[1];
    push.data.header_third  = hdr_cur[2];
    push.data.header_fourth = hdr_cur[3];
  end

endmodule

FILE: hdl/hfbr_queue.sv
// Short result queue between the front end and the output stage.
module hfbr_queue import hfbr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  hfbr_push_t   push,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output hfbr_result_t head
);

  hfbr_result_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign full   = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push.valid && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !push.valid) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

endmodule

FILE: hdl/hfbr_back.sv
// Back end: output register that presents queued results on the result channel.
module hfbr_back import hfbr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  hfbr_result_t q_head,
  output logic         q_pop,
  hfbr_out_if.source   out_ch
);

  logic         valid_r;
  hfbr_result_t data_r;
  logic         load;

  assign load  = !q_empty && (!valid_r || out_ch.ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= q_head;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.item_kind     = data_r.item_kind;
  assign out_ch.destination   = data_r.destination;
  assign out_ch.payload_byte  = data_r.payload_byte;
  assign out_ch.header_type   = data_r.header_type;
  assign out_ch.header_length = data_r.header_length;
  assign out_ch.header_third  = data_r.header_third;
  assign out_ch.header_fourth = data_r.header_fourth;

endmodule

FILE: hdl/header_framed_byte_router_unit.sv
// Top level: header framed byte router, front end, result queue and output stage.
//
//   Channel   Direction  Handshake      Carries
//   in_ch     input      valid/ready    data_byte, one raw byte of the stream
//   out_ch    output     valid/ready    one header or routed payload byte per item
//
// One input item is taken per clock cycle while the queue is not full; the front end decides in the same cycle
// whether it completes a header, carries payload or is only stored.
// A result is written into a queue entry and then loaded into the output register,
// from which out_ch presents it.
// Reset (rst_n low at a clock edge) empties the queue and the output register and
// clears the header store and the frame counters; the block is ready straight away.
// in_ch.ready falls only when the four entry queue is full, so a stalled result
// channel holds the input back without losing or repeating any item.
module header_framed_byte_router_unit import hfbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hfbr_in_if.sink     in_ch,
  hfbr_out_if.source  out_ch
);

  // Classified item from the front end, written into the queue when valid.
  hfbr_push_t   push;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  hfbr_result_t q_head;

  // The front end keeps the header bytes, the frame byte count and the count at
  // which the payload ends. It emits a header result on the last header byte and
  // a routed result for each payload byte; lengths that leave no whole group of
  // four payload bytes close the frame right after its header.
  hfbr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // The queue decouples the front end from the output stage, so each side can
  // stall on its own.
  hfbr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  // The output stage reloads its register whenever it is empty or its item is
  // being taken, which keeps one result per cycle flowing while out_ch is ready.
  hfbr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
